// ===== rtl/core/gss3d_pkg.sv =====
`default_nettype none
package gss3d_pkg;

    localparam int GRID_N     = 16;
    localparam int CELL_COUNT = GRID_N * GRID_N * GRID_N;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int COORD_W    = $clog2(GRID_N);
    localparam int EDGE_HI    = GRID_N - 1;
    localparam int INNER_HI   = GRID_N - 2;

    localparam int DATA_W    = 32;
    localparam int GAIN_W    = 31;
    localparam int SUM_W     = 35;
    localparam int MUL_VAL_W = 49;
    localparam int MUL_LO_W  = 24;
    localparam int MUL_OP_W  = MUL_VAL_W - MUL_LO_W + 1;
    localparam int MUL_P_W   = MUL_OP_W + GAIN_W + 1;
    localparam int MUL_F_W   = MUL_P_W + MUL_LO_W;
    localparam int RES_W     = 64;

    localparam logic [GAIN_W-1:0] CORNER_GAIN = GAIN_W'(21627);
    localparam logic signed [RES_W:0] CLAMP_HI = (RES_W + 1)'(64'sh8000_0000_0000);
    localparam logic signed [RES_W:0] CLAMP_LO = -CLAMP_HI;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_SOLVE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [1:0] REG_GAIN   = 2'd0;
    localparam logic [1:0] REG_RECIP  = 2'd1;
    localparam logic [1:0] REG_SWEEPS = 2'd2;
    localparam logic [1:0] REG_BMODE  = 2'd3;

    localparam logic [1:0] AXIS_Z = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_X = 2'd2;

    localparam logic [1:0] BMODE_X = 2'd1;
    localparam logic [1:0] BMODE_Y = 2'd2;
    localparam logic [1:0] BMODE_Z = 2'd3;

    typedef enum logic [1:0] {
        MP_IDLE,
        MP_LO,
        MP_HI,
        MP_SUM
    } t_mul_phase;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INT_RD,
        ST_INT_WAIT,
        ST_M1_GO,
        ST_M1_WAIT,
        ST_M2_GO,
        ST_M2_WAIT,
        ST_FACE,
        ST_FACE_LAST,
        ST_CRN_RD,
        ST_CRN_WAIT,
        ST_CRN_GO,
        ST_CRN_MWAIT,
        ST_DONE
    } t_eng_state;

    typedef struct packed {
        logic [GAIN_W-1:0] gain;
        logic [GAIN_W-1:0] recip;
        logic [6:0]        sweeps;
        logic [1:0]        bmode;
    } t_cfg;

    typedef struct packed {
        logic busy;
        logic done;
        logic sat;
    } t_eng_stat;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [DATA_W-1:0] wr_data;
    } t_fld_req;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              sat;
    } t_sat;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] i,
                                                   input logic [COORD_W-1:0] j,
                                                   input logic [COORD_W-1:0] k);
        int tmp;
        tmp = int'(i) + int'(j) * GRID_N + int'(k) * GRID_N * GRID_N;
        return tmp[ADDR_W-1:0];
    endfunction

    function automatic t_sat sat32(input logic signed [RES_W-1:0] v);
        t_sat r;
        if (v > RES_W'(64'sh7FFF_FFFF)) begin
            r.value = 32'h7FFF_FFFF;
            r.sat   = 1'b1;
        end else if (v < -RES_W'(64'sh8000_0000)) begin
            r.value = 32'h8000_0000;
            r.sat   = 1'b1;
        end else begin
            r.value = v[DATA_W-1:0];
            r.sat   = 1'b0;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/gauss_seidel_stencil_solver_3d.sv =====
`default_nettype none
// Channel   Direction  Ports                   Contents
// s_axis    in         tdata, tuser            cell index, initial value, source; operation
// m_axis    out        tdata, tuser            cell value; solve done, saturated
// apb       in/out     psel .. prdata          gain, reciprocal, sweep count, boundary mode
//
// A load of an in-range index writes both memories when accepted; a read's data passes through
// the field memory's output register and then the result register. A solve runs each interior
// cell through six field memory reads and two multiply passes, then fills the face cells and
// the eight corners, and repeats this for the sweep count.
// Reset is synchronous and clears control state only; the memories hold garbage.
// Input is stalled while a solve or a read is in flight or a result waits.
module gauss_seidel_stencil_solver_3d (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [79:0] s_axis_tdata,  // cell_index, initial_value, source_value
    input  wire logic [1:0]  s_axis_tuser,  // operation
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,  // cell_value
    output logic [1:0]       m_axis_tuser,  // solve_done, saturated
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int AW = gss3d_pkg::ADDR_W;

    gss3d_pkg::t_cfg r_cfg;
    gss3d_pkg::t_eng_stat eng_stat;
    gss3d_pkg::t_fld_req eng_fld, fld;
    logic [gss3d_pkg::DATA_W-1:0] fld_rdata, src_rdata;
    logic [AW-1:0] src_raddr, in_addr;
    logic in_ok, s_acc, cfg_wr;
    logic [1:0] op;
    logic r_rd_pend, r_rd_ok;
    logic r_out_valid, r_out_done, r_out_sat;
    logic [31:0] r_out_value;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign op = s_axis_tuser;
    assign in_addr = AW'(s_axis_tdata[11:0]);
    assign in_ok = (32'(s_axis_tdata[11:0]) < 32'(gss3d_pkg::CELL_COUNT));
    assign s_axis_tready = !eng_stat.busy && !r_rd_pend && (!r_out_valid || m_axis_tready);
    assign s_acc = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain   <= 31'd65536;
            r_cfg.recip  <= 31'd10923;
            r_cfg.sweeps <= 7'd4;
            r_cfg.bmode  <= 2'd0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                gss3d_pkg::REG_GAIN:   r_cfg.gain   <= pwdata[30:0];
                gss3d_pkg::REG_RECIP:  r_cfg.recip  <= pwdata[30:0];
                gss3d_pkg::REG_SWEEPS: r_cfg.sweeps <= pwdata[6:0];
                gss3d_pkg::REG_BMODE:  r_cfg.bmode  <= pwdata[1:0];
                default:               r_cfg.bmode  <= r_cfg.bmode;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            gss3d_pkg::REG_GAIN:   prdata = {1'b0, r_cfg.gain};
            gss3d_pkg::REG_RECIP:  prdata = {1'b0, r_cfg.recip};
            gss3d_pkg::REG_SWEEPS: prdata = {25'd0, r_cfg.sweeps};
            gss3d_pkg::REG_BMODE:  prdata = {30'd0, r_cfg.bmode};
            default:               prdata = 32'd0;
        endcase
    end

    gss3d_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (s_acc && op == gss3d_pkg::OP_SOLVE),
        .i_cfg       (r_cfg),
        .o_stat      (eng_stat),
        .o_fld       (eng_fld),
        .i_fld_rdata (fld_rdata),
        .o_src_addr  (src_raddr),
        .i_src_rdata (src_rdata)
    );

    always_comb begin
        if (eng_stat.busy) begin
            fld = eng_fld;
        end else begin
            fld.rd_en   = s_acc && op == gss3d_pkg::OP_READ;
            fld.rd_addr = in_addr;
            fld.wr_en   = s_acc && op == gss3d_pkg::OP_LOAD && in_ok;
            fld.wr_addr = in_addr;
            fld.wr_data = s_axis_tdata[43:12];
        end
    end

    gss3d_ram #(
        .WIDTH (gss3d_pkg::DATA_W),
        .DEPTH (gss3d_pkg::CELL_COUNT)
    ) u_field_ram (
        .i_clk   (i_clk),
        .i_we    (fld.wr_en),
        .i_waddr (fld.wr_addr),
        .i_wdata (fld.wr_data),
        .i_re    (fld.rd_en),
        .i_raddr (fld.rd_addr),
        .o_rdata (fld_rdata)
    );

    gss3d_ram #(
        .WIDTH (gss3d_pkg::DATA_W),
        .DEPTH (gss3d_pkg::CELL_COUNT)
    ) u_source_ram (
        .i_clk   (i_clk),
        .i_we    (s_acc && op == gss3d_pkg::OP_LOAD && in_ok),
        .i_waddr (in_addr),
        .i_wdata (s_axis_tdata[75:44]),
        .i_re    (1'b1),
        .i_raddr (src_raddr),
        .o_rdata (src_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_pend <= s_acc && op == gss3d_pkg::OP_READ;
            if (r_rd_pend || eng_stat.done) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_rd_ok <= in_ok;
        end
        if (r_rd_pend) begin
            r_out_value <= r_rd_ok ? fld_rdata : 32'd0;
            r_out_done  <= 1'b0;
            r_out_sat   <= eng_stat.sat;
        end else if (eng_stat.done) begin
            r_out_value <= 32'd0;
            r_out_done  <= 1'b1;
            r_out_sat   <= eng_stat.sat;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_value;
    assign m_axis_tuser  = {r_out_sat, r_out_done};

`ifndef SYNTHESIS
    a_done_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eng_stat.done |-> !r_out_valid)
        else $error("solve finished while a result was still held");
    a_read_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |-> !r_out_valid && !eng_stat.busy)
        else $error("read data returned into a busy result slot");
    a_done_reported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eng_stat.done |=> r_out_valid && r_out_done)
        else $error("solve completion not reported");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(eng_stat.busy) |-> !r_rd_pend)
        else $error("solve started with a read in flight");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/gss3d_ram.sv =====
`default_nettype none
module gss3d_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/gss3d_mul.sv =====
`default_nettype none
module gss3d_mul (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_start,
    input  wire logic signed [gss3d_pkg::MUL_VAL_W-1:0] i_val,
    input  wire logic        [gss3d_pkg::GAIN_W-1:0]    i_gain,
    output logic                                        o_done,
    output logic signed      [gss3d_pkg::RES_W-1:0]     o_res
);

    gss3d_pkg::t_mul_phase r_phase, n_phase;
    logic signed [gss3d_pkg::MUL_VAL_W-1:0] r_v;
    logic [gss3d_pkg::GAIN_W-1:0] r_g;
    logic signed [gss3d_pkg::MUL_P_W-1:0] r_plo, r_phi;
    logic signed [gss3d_pkg::MUL_OP_W-1:0] m_a;
    logic signed [gss3d_pkg::GAIN_W:0] m_b;
    logic signed [gss3d_pkg::MUL_P_W-1:0] m_p;
    logic signed [gss3d_pkg::MUL_F_W-1:0] m_full, m_sh;

    // The operand is split in a low unsigned part and a high signed part,
    // multiplied in two passes through one multiplier.
    assign m_a = (r_phase == gss3d_pkg::MP_LO)
        ? $signed({{(gss3d_pkg::MUL_OP_W - gss3d_pkg::MUL_LO_W){1'b0}},
                   r_v[gss3d_pkg::MUL_LO_W-1:0]})
        : $signed({r_v[gss3d_pkg::MUL_VAL_W-1], r_v[gss3d_pkg::MUL_VAL_W-1:gss3d_pkg::MUL_LO_W]});
    assign m_b = $signed({1'b0, r_g});
    assign m_p = m_a * m_b;
    assign m_full = (gss3d_pkg::MUL_F_W'(r_phi) <<< gss3d_pkg::MUL_LO_W)
                  + gss3d_pkg::MUL_F_W'(r_plo);
    assign m_sh = m_full >>> 16;

    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            gss3d_pkg::MP_IDLE: if (i_start) n_phase = gss3d_pkg::MP_LO;
            gss3d_pkg::MP_LO:   n_phase = gss3d_pkg::MP_HI;
            gss3d_pkg::MP_HI:   n_phase = gss3d_pkg::MP_SUM;
            gss3d_pkg::MP_SUM:  n_phase = gss3d_pkg::MP_IDLE;
            default:            n_phase = gss3d_pkg::MP_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= gss3d_pkg::MP_IDLE;
            o_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            o_done  <= (r_phase == gss3d_pkg::MP_SUM);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && r_phase == gss3d_pkg::MP_IDLE) begin
            r_v <= i_val;
            r_g <= i_gain;
        end
        if (r_phase == gss3d_pkg::MP_LO) begin
            r_plo <= m_p;
        end
        if (r_phase == gss3d_pkg::MP_HI) begin
            r_phi <= m_p;
        end
        if (r_phase == gss3d_pkg::MP_SUM) begin
            o_res <= m_sh[gss3d_pkg::RES_W-1:0];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/gss3d_engine.sv =====
`default_nettype none
module gss3d_engine (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_start,
    input  wire gss3d_pkg::t_cfg                      i_cfg,
    output gss3d_pkg::t_eng_stat                      o_stat,
    output gss3d_pkg::t_fld_req                       o_fld,
    input  wire logic [gss3d_pkg::DATA_W-1:0]         i_fld_rdata,
    output logic      [gss3d_pkg::ADDR_W-1:0]         o_src_addr,
    input  wire logic [gss3d_pkg::DATA_W-1:0]         i_src_rdata
);

    localparam int CW = gss3d_pkg::COORD_W;
    localparam logic [CW-1:0] C_ONE  = CW'(1);
    localparam logic [CW-1:0] C_ZERO = CW'(0);
    localparam logic [CW-1:0] C_EDGE = CW'(gss3d_pkg::EDGE_HI);
    localparam logic [CW-1:0] C_LAST = CW'(gss3d_pkg::INNER_HI);

    gss3d_pkg::t_eng_state r_state, n_state;
    logic [CW-1:0] r_i, n_i, r_j, n_j, r_k, n_k;
    logic [2:0] r_nb, n_nb, r_cr, n_cr;
    logic [6:0] r_sweep, n_sweep;
    logic signed [gss3d_pkg::SUM_W-1:0] r_sum, n_sum;
    logic r_acc_v, n_acc_v;
    logic r_fw_v, n_fw_v;
    logic [gss3d_pkg::ADDR_W-1:0] r_fw_addr, n_fw_addr;
    logic r_fw_neg, n_fw_neg;
    logic signed [gss3d_pkg::MUL_VAL_W-1:0] r_u, n_u;
    logic r_sat, n_sat;

    logic mul_start, mul_done;
    logic signed [gss3d_pkg::MUL_VAL_W-1:0] mul_val;
    logic [gss3d_pkg::GAIN_W-1:0] mul_gain;
    logic signed [gss3d_pkg::RES_W-1:0] mul_res;

    logic [CW-1:0] ni, nj, nk, ti, tj, tk, ci, cj, ck;
    logic [1:0] axis;
    logic [CW-1:0] f_edge, f_inner;
    logic signed [gss3d_pkg::RES_W:0] u_w;
    gss3d_pkg::t_sat sv, fv;

    gss3d_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_val   (mul_val),
        .i_gain  (mul_gain),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

    assign o_src_addr = gss3d_pkg::cell_addr(r_i, r_j, r_k);
    assign axis = r_nb[2:1];
    assign f_edge = r_nb[0] ? C_EDGE : C_ZERO;
    assign f_inner = r_nb[0] ? C_LAST : C_ONE;
    assign ci = r_cr[0] ? C_EDGE : C_ZERO;
    assign cj = r_cr[1] ? C_EDGE : C_ZERO;
    assign ck = r_cr[2] ? C_EDGE : C_ZERO;
    assign u_w = (gss3d_pkg::RES_W + 1)'($signed(i_src_rdata))
               + (gss3d_pkg::RES_W + 1)'(mul_res);
    assign sv = gss3d_pkg::sat32(mul_res);
    assign fv = gss3d_pkg::sat32(-gss3d_pkg::RES_W'($signed(i_fld_rdata)));

    always_comb begin
        n_state   = r_state;
        n_i       = r_i;
        n_j       = r_j;
        n_k       = r_k;
        n_nb      = r_nb;
        n_cr      = r_cr;
        n_sweep   = r_sweep;
        n_sum     = r_acc_v ? r_sum + gss3d_pkg::SUM_W'($signed(i_fld_rdata)) : r_sum;
        n_acc_v   = 1'b0;
        n_fw_v    = 1'b0;
        n_fw_addr = r_fw_addr;
        n_fw_neg  = r_fw_neg;
        n_u       = r_u;
        n_sat     = r_sat;
        mul_start = 1'b0;
        mul_val   = gss3d_pkg::MUL_VAL_W'(r_sum);
        mul_gain  = i_cfg.gain;
        o_fld     = '0;
        ni = r_i;
        nj = r_j;
        nk = r_k;
        ti = r_i;
        tj = r_j;
        tk = r_k;

        if (r_fw_v) begin
            o_fld.wr_en   = 1'b1;
            o_fld.wr_addr = r_fw_addr;
            o_fld.wr_data = r_fw_neg ? fv.value : i_fld_rdata;
            if (r_fw_neg && fv.sat) n_sat = 1'b1;
        end

        unique case (r_state)
            gss3d_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_sat = 1'b0;
                    if (i_cfg.sweeps == 7'd0) begin
                        n_state = gss3d_pkg::ST_DONE;
                    end else begin
                        n_i = C_ONE;
                        n_j = C_ONE;
                        n_k = C_ONE;
                        n_nb = 3'd0;
                        n_sum = '0;
                        n_sweep = 7'd0;
                        n_state = gss3d_pkg::ST_INT_RD;
                    end
                end
            end
            gss3d_pkg::ST_INT_RD: begin
                unique case (r_nb)
                    3'd0:    ni = r_i + C_ONE;
                    3'd1:    ni = r_i - C_ONE;
                    3'd2:    nj = r_j + C_ONE;
                    3'd3:    nj = r_j - C_ONE;
                    3'd4:    nk = r_k + C_ONE;
                    default: nk = r_k - C_ONE;
                endcase
                o_fld.rd_en = 1'b1;
                o_fld.rd_addr = gss3d_pkg::cell_addr(ni, nj, nk);
                n_acc_v = 1'b1;
                if (r_nb == 3'd5) begin
                    n_nb = 3'd0;
                    n_state = gss3d_pkg::ST_INT_WAIT;
                end else begin
                    n_nb = r_nb + 3'd1;
                end
            end
            gss3d_pkg::ST_INT_WAIT: n_state = gss3d_pkg::ST_M1_GO;
            gss3d_pkg::ST_M1_GO: begin
                mul_start = 1'b1;
                n_state = gss3d_pkg::ST_M1_WAIT;
            end
            gss3d_pkg::ST_M1_WAIT: begin
                if (mul_done) begin
                    if (u_w > gss3d_pkg::CLAMP_HI) begin
                        n_u = gss3d_pkg::MUL_VAL_W'(gss3d_pkg::CLAMP_HI);
                    end else if (u_w < gss3d_pkg::CLAMP_LO) begin
                        n_u = gss3d_pkg::MUL_VAL_W'(gss3d_pkg::CLAMP_LO);
                    end else begin
                        n_u = gss3d_pkg::MUL_VAL_W'(u_w);
                    end
                    n_state = gss3d_pkg::ST_M2_GO;
                end
            end
            gss3d_pkg::ST_M2_GO: begin
                mul_start = 1'b1;
                mul_val = r_u;
                mul_gain = i_cfg.recip;
                n_state = gss3d_pkg::ST_M2_WAIT;
            end
            gss3d_pkg::ST_M2_WAIT: begin
                if (mul_done) begin
                    o_fld.wr_en = 1'b1;
                    o_fld.wr_addr = gss3d_pkg::cell_addr(r_i, r_j, r_k);
                    o_fld.wr_data = sv.value;
                    if (sv.sat) n_sat = 1'b1;
                    n_sum = '0;
                    n_state = gss3d_pkg::ST_INT_RD;
                    if (r_i == C_LAST) begin
                        n_i = C_ONE;
                        if (r_j == C_LAST) begin
                            n_j = C_ONE;
                            if (r_k == C_LAST) begin
                                n_k = C_ONE;
                                n_nb = 3'd0;
                                n_state = gss3d_pkg::ST_FACE;
                            end else begin
                                n_k = r_k + C_ONE;
                            end
                        end else begin
                            n_j = r_j + C_ONE;
                        end
                    end else begin
                        n_i = r_i + C_ONE;
                    end
                end
            end
            gss3d_pkg::ST_FACE: begin
                unique case (axis)
                    gss3d_pkg::AXIS_Z: begin
                        nk = f_inner;
                        tk = f_edge;
                        n_fw_neg = (i_cfg.bmode == gss3d_pkg::BMODE_Z);
                    end
                    gss3d_pkg::AXIS_Y: begin
                        nj = f_inner;
                        tj = f_edge;
                        nk = r_j;
                        tk = r_j;
                        n_fw_neg = (i_cfg.bmode == gss3d_pkg::BMODE_Y);
                    end
                    default: begin
                        ni = f_inner;
                        ti = f_edge;
                        nj = r_i;
                        tj = r_i;
                        nk = r_j;
                        tk = r_j;
                        n_fw_neg = (i_cfg.bmode == gss3d_pkg::BMODE_X);
                    end
                endcase
                o_fld.rd_en = 1'b1;
                o_fld.rd_addr = gss3d_pkg::cell_addr(ni, nj, nk);
                n_fw_v = 1'b1;
                n_fw_addr = gss3d_pkg::cell_addr(ti, tj, tk);
                if (r_nb == 3'd5) begin
                    n_nb = 3'd0;
                    if (r_i == C_LAST) begin
                        n_i = C_ONE;
                        if (r_j == C_LAST) begin
                            n_j = C_ONE;
                            n_state = gss3d_pkg::ST_FACE_LAST;
                        end else begin
                            n_j = r_j + C_ONE;
                        end
                    end else begin
                        n_i = r_i + C_ONE;
                    end
                end else begin
                    n_nb = r_nb + 3'd1;
                end
            end
            gss3d_pkg::ST_FACE_LAST: begin
                n_cr = 3'd0;
                n_nb = 3'd0;
                n_sum = '0;
                n_state = gss3d_pkg::ST_CRN_RD;
            end
            gss3d_pkg::ST_CRN_RD: begin
                ni = ci;
                nj = cj;
                nk = ck;
                unique case (r_nb)
                    3'd0:    ni = r_cr[0] ? C_LAST : C_ONE;
                    3'd1:    nj = r_cr[1] ? C_LAST : C_ONE;
                    default: nk = r_cr[2] ? C_LAST : C_ONE;
                endcase
                o_fld.rd_en = 1'b1;
                o_fld.rd_addr = gss3d_pkg::cell_addr(ni, nj, nk);
                n_acc_v = 1'b1;
                if (r_nb == 3'd2) begin
                    n_nb = 3'd0;
                    n_state = gss3d_pkg::ST_CRN_WAIT;
                end else begin
                    n_nb = r_nb + 3'd1;
                end
            end
            gss3d_pkg::ST_CRN_WAIT: n_state = gss3d_pkg::ST_CRN_GO;
            gss3d_pkg::ST_CRN_GO: begin
                mul_start = 1'b1;
                mul_gain = gss3d_pkg::CORNER_GAIN;
                n_state = gss3d_pkg::ST_CRN_MWAIT;
            end
            gss3d_pkg::ST_CRN_MWAIT: begin
                if (mul_done) begin
                    o_fld.wr_en = 1'b1;
                    o_fld.wr_addr = gss3d_pkg::cell_addr(ci, cj, ck);
                    o_fld.wr_data = sv.value;
                    if (sv.sat) n_sat = 1'b1;
                    n_sum = '0;
                    if (r_cr == 3'd7) begin
                        if (r_sweep + 7'd1 == i_cfg.sweeps) begin
                            n_state = gss3d_pkg::ST_DONE;
                        end else begin
                            n_sweep = r_sweep + 7'd1;
                            n_i = C_ONE;
                            n_j = C_ONE;
                            n_k = C_ONE;
                            n_nb = 3'd0;
                            n_state = gss3d_pkg::ST_INT_RD;
                        end
                    end else begin
                        n_cr = r_cr + 3'd1;
                        n_state = gss3d_pkg::ST_CRN_RD;
                    end
                end
            end
            gss3d_pkg::ST_DONE: n_state = gss3d_pkg::ST_IDLE;
            default: n_state = gss3d_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gss3d_pkg::ST_IDLE;
            r_acc_v <= 1'b0;
            r_fw_v  <= 1'b0;
            r_sat   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_acc_v <= n_acc_v;
            r_fw_v  <= n_fw_v;
            r_sat   <= n_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i       <= n_i;
        r_j       <= n_j;
        r_k       <= n_k;
        r_nb      <= n_nb;
        r_cr      <= n_cr;
        r_sweep   <= n_sweep;
        r_sum     <= n_sum;
        r_fw_addr <= n_fw_addr;
        r_fw_neg  <= n_fw_neg;
        r_u       <= n_u;
    end

    assign o_stat.busy = (r_state != gss3d_pkg::ST_IDLE);
    assign o_stat.done = (r_state == gss3d_pkg::ST_DONE);
    assign o_stat.sat  = r_sat;

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
module tb;
    import gss3d_pkg::*;

    localparam longint CYCLE_LIMIT = 4_000_000;

    typedef struct packed {
        logic [31:0] cell_value;
        logic        solve_done;
        logic        saturated;
    } t_cell_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_valid;
    logic        s_ready;
    logic [79:0] s_data;
    logic [1:0]  s_user;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_data;
    logic [1:0]  m_user;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    gauss_seidel_stencil_solver_3d u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_user),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tuser  (m_user),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    logic signed [31:0] field_cells [CELL_COUNT];
    logic signed [31:0] source_cells [CELL_COUNT];
    logic               sat_seen;
    logic [30:0]        gain_a;
    logic [30:0]        recip_c;
    logic [6:0]         sweeps;
    logic [1:0]         bmode;

    t_cell_result expected_results [$];
    int           errors;
    longint       cycles = 0;
    int           hold_len = 0;
    int           stall_left = 0;
    bit           quiet;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic int ix(input int i, input int j, input int k);
        return i + j * GRID_N + k * GRID_N * GRID_N;
    endfunction

    // floor(v * g / 2^16) without overflowing 64 bits
    function automatic longint scale_q16(input longint v, input longint g);
        longint hi;
        longint lo;
        hi = v >>> 16;
        lo = v - hi * 65536;
        return hi * g + ((lo * g) >>> 16);
    endfunction

    function automatic logic [31:0] clip32(input longint v);
        if (v > 64'sd2147483647) begin
            sat_seen = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < -64'sd2147483648) begin
            sat_seen = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic [31:0] face_of(input int from, input bit neg);
        longint v;
        v = field_cells[from];
        return neg ? clip32(-v) : v[31:0];
    endfunction

    function automatic void set_corner(input int dst, input int n1, input int n2, input int n3);
        longint s;
        s = longint'(field_cells[n1]) + field_cells[n2] + field_cells[n3];
        field_cells[dst] = clip32(scale_q16(s, 21627));
    endfunction

    function automatic void relax_grid();
        int e;
        int f;
        longint s;
        longint u;
        bit nx;
        bit ny;
        bit nz;
        e = GRID_N - 1;
        f = GRID_N - 2;
        nx = (bmode == BMODE_X);
        ny = (bmode == BMODE_Y);
        nz = (bmode == BMODE_Z);
        sat_seen = 1'b0;
        for (int n = 0; n < sweeps; n++) begin
            for (int k = 1; k < e; k++)
                for (int j = 1; j < e; j++)
                    for (int i = 1; i < e; i++) begin
                        s = longint'(field_cells[ix(i + 1, j, k)]) + field_cells[ix(i - 1, j, k)]
                            + field_cells[ix(i, j + 1, k)] + field_cells[ix(i, j - 1, k)]
                            + field_cells[ix(i, j, k + 1)] + field_cells[ix(i, j, k - 1)];
                        u = longint'(source_cells[ix(i, j, k)]) + scale_q16(s, gain_a);
                        if (u > (64'sd1 <<< 47)) u = 64'sd1 <<< 47;
                        if (u < -(64'sd1 <<< 47)) u = -(64'sd1 <<< 47);
                        field_cells[ix(i, j, k)] = clip32(scale_q16(u, recip_c));
                    end
            for (int q = 1; q < e; q++)
                for (int p = 1; p < e; p++) begin
                    field_cells[ix(p, q, 0)] = face_of(ix(p, q, 1), nz);
                    field_cells[ix(p, q, e)] = face_of(ix(p, q, f), nz);
                end
            for (int q = 1; q < e; q++)
                for (int p = 1; p < e; p++) begin
                    field_cells[ix(p, 0, q)] = face_of(ix(p, 1, q), ny);
                    field_cells[ix(p, e, q)] = face_of(ix(p, f, q), ny);
                end
            for (int q = 1; q < e; q++)
                for (int p = 1; p < e; p++) begin
                    field_cells[ix(0, p, q)] = face_of(ix(1, p, q), nx);
                    field_cells[ix(e, p, q)] = face_of(ix(f, p, q), nx);
                end
            set_corner(ix(0, 0, 0), ix(1, 0, 0), ix(0, 1, 0), ix(0, 0, 1));
            set_corner(ix(0, e, 0), ix(1, e, 0), ix(0, f, 0), ix(0, e, 1));
            set_corner(ix(0, 0, e), ix(1, 0, e), ix(0, 1, e), ix(0, 0, f));
            set_corner(ix(0, e, e), ix(1, e, e), ix(0, f, e), ix(0, e, f));
            set_corner(ix(e, 0, 0), ix(f, 0, 0), ix(e, 1, 0), ix(e, 0, 1));
            set_corner(ix(e, e, 0), ix(f, e, 0), ix(e, f, 0), ix(e, e, 1));
            set_corner(ix(e, 0, e), ix(f, 0, e), ix(e, 1, e), ix(e, 0, f));
            set_corner(ix(e, e, e), ix(f, e, e), ix(e, f, e), ix(e, e, f));
        end
    endfunction

    function automatic void predict_item(input logic [1:0] op, input logic [11:0] idx,
                                         input logic [31:0] init, input logic [31:0] src);
        t_cell_result r;
        case (op)
            OP_LOAD: begin
                field_cells[idx] = init;
                source_cells[idx] = src;
            end
            OP_SOLVE: begin
                relax_grid();
                r.cell_value = '0;
                r.solve_done = 1'b1;
                r.saturated  = sat_seen;
                expected_results.push_back(r);
            end
            OP_READ: begin
                r.cell_value = field_cells[idx];
                r.solve_done = 1'b0;
                r.saturated  = sat_seen;
                expected_results.push_back(r);
            end
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_cell_result want;
        if (i_rst_n && m_valid && m_ready) begin
            stall_left = quiet ? 0 : $urandom_range(0, 7);
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result data=%h user=%b", $time, m_data, m_user);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (m_data !== want.cell_value) begin
                    $display("%0t: cell_value expected %h actual %h", $time, want.cell_value,
                             m_data);
                    errors++;
                end
                if (m_user[0] !== want.solve_done) begin
                    $display("%0t: solve_done expected %b actual %b", $time, want.solve_done,
                             m_user[0]);
                    errors++;
                end
                if (m_user[1] !== want.saturated) begin
                    $display("%0t: saturated expected %b actual %b", $time, want.saturated,
                             m_user[1]);
                    errors++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_len > 0) begin
            m_ready <= 1'b0;
            hold_len--;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [11:0] idx,
                             input logic [31:0] init, input logic [31:0] src);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            @(negedge i_clk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_valid <= 1'b1;
        s_user  <= op;
        s_data  <= {4'b0, src, init, idx};
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        predict_item(op, idx, init, src);
    endtask

    task automatic end_burst();
        @(negedge i_clk);
        s_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        end_burst();
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] sel, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (sel)
            REG_GAIN:   gain_a  = value[30:0];
            REG_RECIP:  recip_c = value[30:0];
            REG_SWEEPS: sweeps  = value[6:0];
            default:    bmode   = value[1:0];
        endcase
    endtask

    task automatic set_solver(input logic [31:0] g, input logic [31:0] c,
                              input logic [31:0] n, input logic [31:0] b);
        write_reg(REG_GAIN, g);
        write_reg(REG_RECIP, c);
        write_reg(REG_SWEEPS, n);
        write_reg(REG_BMODE, b);
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        endcase
    endfunction

    task automatic test_fill_grid();
        quiet = 1'b1;
        for (int n = 0; n < CELL_COUNT; n++)
            send_item(OP_LOAD, n[11:0], rand_value(), rand_value());
        quiet = 1'b0;
        wait_drained();
    endtask

    task automatic test_directed();
        send_item(OP_LOAD, 12'd0, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(OP_LOAD, 12'hFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(OP_READ, 12'd0, '0, '0);
        send_item(OP_READ, 12'hFFF, '0, '0);
        send_item(2'd3, 12'h555, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_READ, 12'hAAA, '0, '0);
        wait_drained();
        set_solver(32'd65536, 32'd10923, 32'd0, 32'd0);
        send_item(OP_SOLVE, '0, '0, '0);
        send_item(OP_READ, 12'd0, '0, '0);
        wait_drained();
        for (int b = 1; b <= 3; b++) begin
            set_solver(32'd0, 32'h7FFF_FFFF, 32'd1, b);
            send_item(OP_SOLVE, '0, '0, '0);
            send_item(OP_READ, 12'(ix(1, 1, 0)), '0, '0);
            send_item(OP_READ, 12'(ix(0, 0, GRID_N - 1)), '0, '0);
            send_item(OP_READ, 12'(ix(5, 7, 9)), '0, '0);
            wait_drained();
        end
        set_solver(32'h7FFF_FFFF, 32'd1, 32'd1, 32'd0);
        send_item(OP_SOLVE, '0, '0, '0);
        send_item(OP_READ, 12'(ix(GRID_N - 1, GRID_N - 1, GRID_N - 1)), '0, '0);
        wait_drained();
        set_solver(32'd65536, 32'd10923, 32'd127, 32'd0);
    endtask

    task automatic test_backpressure();
        quiet = 1'b1;
        hold_len = 300;
        for (int n = 0; n < 12; n++)
            send_item(OP_READ, 12'($urandom_range(0, CELL_COUNT - 1)), '0, '0);
        quiet = 1'b0;
        wait_drained();
    endtask

    task automatic test_random_traffic();
        logic [31:0] g;
        for (int phase = 0; phase < 4; phase++) begin
            if ($urandom_range(0, 1)) begin
                g = $urandom_range(0, 131072);
                set_solver(g, 32'((64'd1 << 32) / (64'd65536 + 64'd6 * 64'(g))),
                           $urandom_range(1, 2), $urandom_range(0, 3));
            end else begin
                set_solver($urandom(), $urandom(), 1, $urandom_range(0, 3));
            end
            quiet = (phase == 2);
            for (int n = 0; n < 220; n++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: send_item(OP_LOAD, 12'($urandom()), rand_value(), rand_value());
                    4: send_item(2'd3, 12'($urandom()), $urandom(), $urandom());
                    default: send_item(OP_READ, 12'($urandom()), '0, '0);
                endcase
                if (n == 100) begin
                    end_burst();
                    while (expected_results.size() != 0) @(posedge i_clk);
                end
            end
            quiet = 1'b0;
            send_item(OP_SOLVE, 12'($urandom()), $urandom(), $urandom());
            for (int n = 0; n < 8; n++)
                send_item(OP_READ, 12'($urandom()), '0, '0);
            wait_drained();
        end
    endtask

    initial begin
        errors   = 0;
        cycles   = 0;
        hold_len = 0;
        stall_left = 0;
        quiet    = 1'b0;
        sat_seen = 1'b0;
        gain_a   = 31'd65536;
        recip_c  = 31'd10923;
        sweeps   = 7'd4;
        bmode    = 2'd0;
        i_rst_n  = 1'b0;
        s_valid  = 1'b0;
        s_data   = '0;
        s_user   = '0;
        m_ready  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_fill_grid();
        test_directed();
        test_backpressure();
        test_random_traffic();
        wait_drained();
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
